/* rtl/core/fpd_pkg.sv */
// ----------------------------------------------------------------------------
// Packet deframer package
// Shared constants, codes and the command record passed from the parser
// to the replay engine.
// ----------------------------------------------------------------------------
package fpd_pkg;

  localparam int unsigned MAX_LEN = 32;
  localparam int unsigned IDX_W = $clog2(MAX_LEN);
  localparam int unsigned FILL_W = IDX_W + 1;
  localparam logic [7:0] START_RESET = 8'h99;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_CKSUM_ERR = 2'd2,
    KIND_TOO_LONG  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_EMIT   = 2'd1,
    OP_REPLAY = 2'd2
  } op_e;

  typedef struct packed {
    op_e              op;
    kind_e            kind;
    logic [7:0]       id;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic [7:0]       len;
    logic [7:0]       fail;
  } cmd_t;

endpackage

/* rtl/core/fpd_front.sv */
// ----------------------------------------------------------------------------
// Packet deframer parser
// Hunts for the start byte, tracks the running sums and turns each received
// byte into at most one command for the replay engine.
// ----------------------------------------------------------------------------
module fpd_front import fpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push,
  input  logic [7:0] rx_byte_i,
  input  logic       cmd_full_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_ID,
    PH_DATA,
    PH_CK1,
    PH_CK2
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [7:0]         start_q;
  logic [7:0]         sum_a_q, sum_a_d;
  logic [7:0]         sum_b_q, sum_b_d;
  logic [7:0]         id_q, id_d;
  logic [7:0]         len_q, len_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [7:0]         fail_q, fail_d;
  logic [7:0]         sum_a_add;
  logic [7:0]         expect_sum;
  logic               accept;

  assign accept = push && !cmd_full_i;
  assign sum_a_add = sum_a_q + rx_byte_i;
  assign expect_sum = (phase_q == PH_CK1) ? sum_a_q : sum_b_q;

  always_comb begin
    phase_d = phase_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    id_d = id_q;
    len_d = len_q;
    fill_d = fill_q;
    fail_d = fail_q;
    cmd_push_o = 1'b0;
    cmd_o = '0;
    cmd_o.fail = fail_q;
    if (accept) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == start_q) begin
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          len_d = rx_byte_i;
          id_d = '0;
          if (rx_byte_i > 8'(MAX_LEN)) begin
            cmd_push_o = 1'b1;
            cmd_o.op = OP_EMIT;
            cmd_o.kind = KIND_TOO_LONG;
            cmd_o.len = rx_byte_i;
            phase_d = PH_HUNT;
          end else begin
            sum_a_d = rx_byte_i;
            sum_b_d = rx_byte_i;
            phase_d = PH_ID;
          end
        end
        PH_ID: begin
          id_d = rx_byte_i;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_q + sum_a_add;
          fill_d = '0;
          phase_d = (len_q == 8'd0) ? PH_CK1 : PH_DATA;
        end
        PH_DATA: begin
          cmd_push_o = 1'b1;
          cmd_o.op = OP_WRITE;
          cmd_o.idx = fill_q[IDX_W-1:0];
          cmd_o.data = rx_byte_i;
          fill_d = fill_q + 1'b1;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_q + sum_a_add;
          if (8'(fill_d) >= len_q) begin
            phase_d = PH_CK1;
          end
        end
        PH_CK1, PH_CK2: begin
          if (rx_byte_i != expect_sum) begin
            fail_d = fail_q + 8'd1;
            cmd_push_o = 1'b1;
            cmd_o.op = OP_EMIT;
            cmd_o.kind = KIND_CKSUM_ERR;
            cmd_o.id = id_q;
            cmd_o.len = len_q;
            cmd_o.fail = fail_d;
            phase_d = PH_HUNT;
          end else if (phase_q == PH_CK1) begin
            phase_d = PH_CK2;
          end else begin
            phase_d = PH_HUNT;
            cmd_push_o = 1'b1;
            cmd_o.id = id_q;
            cmd_o.len = len_q;
            if (len_q == 8'd0) begin
              cmd_o.op = OP_EMIT;
              cmd_o.kind = KIND_EMPTY;
            end else begin
              cmd_o.op = OP_REPLAY;
              cmd_o.kind = KIND_DATA;
            end
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      start_q <= START_RESET;
      sum_a_q <= '0;
      sum_b_q <= '0;
      id_q <= '0;
      len_q <= '0;
      fill_q <= '0;
      fail_q <= '0;
    end else begin
      phase_q <= phase_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      id_q <= id_d;
      len_q <= len_d;
      fill_q <= fill_d;
      fail_q <= fail_d;
      if (cfg_we_i) begin
        start_q <= cfg_data_i;
      end
    end
  end

  // A payload byte is only stored while its slot lies inside the packet.
  a_fill_in_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (8'(fill_q) < len_q && len_q <= 8'(MAX_LEN)))
    else $error("payload slot outside packet");

endmodule

/* rtl/core/fpd_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Packet deframer command queue
// Short first-in first-out queue that decouples the parser from the
// replay engine.
// ----------------------------------------------------------------------------
module fpd_cmd_fifo import fpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  input  logic pop_i,
  output cmd_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q;
  logic [FIFO_AW-1:0]   rd_ptr_q;
  logic [FIFO_CW-1:0]   count_q;

  assign full_o = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if ((push_i && !full_o) && !(pop_i && !empty_o)) begin
        count_q <= count_q + 1'b1;
      end else if (!(push_i && !full_o) && (pop_i && !empty_o)) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("command pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("command popped from empty queue");

endmodule

/* rtl/core/fpd_back.sv */
// ----------------------------------------------------------------------------
// Packet deframer replay engine
// Holds the payload store, executes queued commands and drives the result
// register.
// ----------------------------------------------------------------------------
module fpd_back import fpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  input  logic             pop,
  output logic             out_valid_o,
  output logic [1:0]       kind_o,
  output logic [7:0]       packet_id_o,
  output logic [IDX_W-1:0] byte_index_o,
  output logic [7:0]       data_byte_o,
  output logic [7:0]       packet_length_o,
  output logic             is_last_o,
  output logic [7:0]       fail_count_o
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SEND
  } bstate_e;

  bstate_e          state_q;
  logic [7:0]       store [MAX_LEN];
  logic [7:0]       rd_q;
  logic [IDX_W-1:0] idx_q;
  logic [7:0]       id_q;
  logic [7:0]       len_q;
  logic [7:0]       fail_q;
  logic             out_valid_q;
  logic             out_free;
  logic             out_load;
  logic             rep_last;

  assign out_free = !out_valid_q || pop;
  assign out_load = out_free &&
                    (((state_q == B_IDLE) && cmd_valid_i && (cmd_i.op == OP_EMIT)) ||
                     (state_q == B_SEND));
  assign rep_last = (8'(idx_q) == len_q - 8'd1);
  assign cmd_pop_o = (state_q == B_IDLE) && cmd_valid_i &&
                     ((cmd_i.op != OP_EMIT) || out_free);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && cmd_valid_i && cmd_i.op == OP_WRITE) begin
      store[cmd_i.idx] <= cmd_i.data;
    end
    if (state_q == B_READ) begin
      rd_q <= store[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      out_valid_q <= 1'b0;
      idx_q <= '0;
      id_q <= '0;
      len_q <= '0;
      fail_q <= '0;
      kind_o <= '0;
      packet_id_o <= '0;
      byte_index_o <= '0;
      data_byte_o <= '0;
      packet_length_o <= '0;
      is_last_o <= 1'b0;
      fail_count_o <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.op)
              OP_EMIT: begin
                if (out_free) begin
                  kind_o <= cmd_i.kind;
                  packet_id_o <= cmd_i.id;
                  byte_index_o <= '0;
                  data_byte_o <= '0;
                  packet_length_o <= cmd_i.len;
                  is_last_o <= 1'b1;
                  fail_count_o <= cmd_i.fail;
                end
              end
              OP_REPLAY: begin
                idx_q <= '0;
                id_q <= cmd_i.id;
                len_q <= cmd_i.len;
                fail_q <= cmd_i.fail;
                state_q <= B_READ;
              end
              default: begin
              end
            endcase
          end
        end
        B_READ: begin
          state_q <= B_SEND;
        end
        B_SEND: begin
          if (out_free) begin
            kind_o <= KIND_DATA;
            packet_id_o <= id_q;
            byte_index_o <= idx_q;
            data_byte_o <= rd_q;
            packet_length_o <= len_q;
            is_last_o <= rep_last;
            fail_count_o <= fail_q;
            if (rep_last) begin
              state_q <= B_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
              state_q <= B_READ;
            end
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  // Replay never runs past the packet length.
  a_replay_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SEND) |-> (8'(idx_q) < len_q))
    else $error("replay index beyond packet length");

endmodule

/* rtl/core/fletcher_packet_deframer.sv */
// ----------------------------------------------------------------------------
// Fletcher packet deframer
// Byte-stream deframer with two running 8-bit checksums and payload replay.
// ----------------------------------------------------------------------------
// Received bytes enter on a queue-style port: a byte is taken on a clock
// edge where push is high and full is low. Results leave on a second
// queue-style port: while empty is low the oldest result is on the output
// ports, and it is taken on an edge where pop is high.
// The start byte register is written through cfg_we_i and cfg_data_i and
// resets to 0x99.
// Each byte yields at most one command into a four-entry queue. A single
// result (empty packet, checksum failure or oversize length) is written
// into the queue and reaches the output register once the replay engine is
// idle and the output register is free. The first payload byte of a good
// packet follows the second checksum byte through the queue, the store read
// register and the output register; the rest follow byte by byte, each set
// by a registered store read followed by the output register load.
// When the receiver stalls, the replay engine holds, the command queue
// fills and full rises; bytes are then held off until space frees up.
// Reset returns the parser to hunting, empties the queue and clears the
// failure counter; the payload store needs no clearing.
// ----------------------------------------------------------------------------
module fletcher_packet_deframer import fpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [7:0] packet_id_o,
  output logic [4:0] byte_index_o,
  output logic [7:0] data_byte_o,
  output logic [7:0] packet_length_o,
  output logic       is_last_o,
  output logic [7:0] fail_count_o
);

  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_full;
  logic cmd_empty;
  logic cmd_pop;
  logic out_valid;

  assign full = cmd_full;
  assign empty = !out_valid;

  fpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .rx_byte_i  (rx_byte_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  fpd_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  fpd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (!cmd_empty),
    .cmd_i           (cmd_out),
    .cmd_pop_o       (cmd_pop),
    .pop             (pop),
    .out_valid_o     (out_valid),
    .kind_o          (kind_o),
    .packet_id_o     (packet_id_o),
    .byte_index_o    (byte_index_o),
    .data_byte_o     (data_byte_o),
    .packet_length_o (packet_length_o),
    .is_last_o       (is_last_o),
    .fail_count_o    (fail_count_o)
  );

endmodule
